// ===== hdl/sector_extent_map_lookup_defines.svh =====
// Assertion macros shared by the sector extent map RTL.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in the user.
`ifndef SECTOR_EXTENT_MAP_LOOKUP_DEFINES_SVH
`define SECTOR_EXTENT_MAP_LOOKUP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SEM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SEM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/sem_pkg.sv =====
// Package for the sector extent map: sizes, codes, transaction structs and helpers.
// No dependencies; used by the top level of the block, sector_extent_map_lookup.
package sem_pkg;

    localparam int MAX_EXTENTS  = 1024;
    localparam int SECTOR_BYTES = 2048;
    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
    localparam int IDX_W        = $clog2(MAX_EXTENTS);
    localparam int CNT_W        = $clog2(MAX_EXTENTS + 1);
    localparam int OFF_W        = 32 + SECTOR_SHIFT;
    localparam int DATA_W       = 12;
    localparam int PADDR_W      = 3;

    localparam logic [7:0]        DIR_FILL   = 8'hff;
    localparam logic [DATA_W-1:0] DATA_MAX   = {DATA_W{1'b1}};
    localparam logic              REG_TOTAL  = 1'b0;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [1:0] KIND_VOLUME = 2'd0;
    localparam logic [1:0] KIND_DIR    = 2'd1;
    localparam logic [1:0] KIND_FILE   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] sector_number;
        logic [31:0] entry_start;
        logic [31:0] entry_sectors;
        logic [1:0]  entry_kind;
        logic [31:0] entry_bytes;
        logic [15:0] entry_tag;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic              found;
        logic [1:0]        hit_kind;
        logic [15:0]       hit_tag;
        logic [31:0]       byte_offset;
        logic [DATA_W-1:0] data_bytes;
        logic [7:0]        fill_byte;
    } t_out_item;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] sectors;
        logic [1:0]  kind;
        logic [31:0] bytes;
        logic [15:0] tag;
    } t_entry;

    function automatic logic [DATA_W-1:0] clamp_data(input logic [31:0] value);
        logic [DATA_W-1:0] result;
        if (value > 32'(DATA_MAX)) begin
            result = DATA_MAX;
        end else begin
            result = value[DATA_W-1:0];
        end
        return result;
    endfunction

endpackage

// ===== hdl/sem_extent_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
// Holds the extent table of the sector extent map; no other dependencies.
module sem_extent_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/sector_extent_map_lookup.sv =====
// Top level of the sector extent map: APB register, sequencer and result register.
// Depends on sem_pkg, sem_extent_ram and sector_extent_map_lookup_defines.svh.
// A clear or append transaction goes from the idle state straight to the emit
// state, which moves its result to the output register. A lookup runs a binary
// search through the single read port of the extent memory: each probe is an
// address state, then a compare on the registered read data, and a lookup over
// N held entries takes at most ceil(log2(N+1)) probes, then the offset, length
// and emit states on a hit; a range error or an empty search finishes sooner. The
// input is stalled from acceptance until the result is moved to the output
// register, which can hold one result while the next transaction is accepted.
// Reset empties the table by clearing the entry count only; the memory itself is
// never cleared; entries are written in order so only written entries are ever probed.
`include "sector_extent_map_lookup_defines.svh"

module sector_extent_map_lookup
    import sem_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_CMP  = 6'b000100,
        S_OFF  = 6'b001000,
        S_LEN  = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [31:0]        r_total, n_total;
    logic [CNT_W-1:0]   r_held, n_held;
    logic [CNT_W-1:0]   r_lo, n_lo;
    logic [CNT_W-1:0]   r_hix, n_hix;
    logic [IDX_W-1:0]   r_mid, n_mid;
    logic [31:0]        r_sec, n_sec;
    logic [OFF_W-1:0]   r_off, n_off;
    t_out_item          r_res, n_res;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic               in_acc;
    logic               cfg_wr;
    logic               wr_en;
    t_entry             wr_entry;
    logic               rd_en;
    t_entry             rd_entry;
    logic [CNT_W:0]     mid_sum;
    logic [IDX_W-1:0]   mid_idx;
    logic [32:0]        end_sec;
    logic [31:0]        rel_sec;
    logic [31:0]        avail;
    logic [31:0]        n_sec_bytes;
    logic               off_sat;

    assign in_acc = i_in_valid && !o_in_stall;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TOTAL) ? r_total : 32'd0;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign wr_entry = '{start:   i_in_item.entry_start,
                        sectors: i_in_item.entry_sectors,
                        kind:    i_in_item.entry_kind,
                        bytes:   i_in_item.entry_bytes,
                        tag:     i_in_item.entry_tag};
    assign wr_en = in_acc && (i_in_item.opcode == OP_APPEND)
                   && (i_in_item.entry_sectors != 32'd0)
                   && (r_held < CNT_W'(MAX_EXTENTS));

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hix} - (CNT_W+1)'(1);
    assign mid_idx = mid_sum[IDX_W:1];
    assign rd_en   = (r_state == S_READ) && (r_lo < r_hix);

    sem_extent_ram #(
        .DEPTH (MAX_EXTENTS),
        .WIDTH ($bits(t_entry))
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_held[IDX_W-1:0]),
        .i_wr_data (wr_entry),
        .i_rd_en   (rd_en),
        .i_rd_addr (mid_idx),
        .o_rd_data (rd_entry)
    );

    assign end_sec     = {1'b0, rd_entry.start} + {1'b0, rd_entry.sectors};
    assign rel_sec     = r_sec - rd_entry.start;
    assign off_sat     = |r_off[OFF_W-1:32];
    assign avail       = (!off_sat && (r_off[31:0] < rd_entry.bytes))
                         ? (rd_entry.bytes - r_off[31:0]) : 32'd0;
    assign n_sec_bytes = (avail > 32'(SECTOR_BYTES)) ? 32'(SECTOR_BYTES) : avail;

    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_held      = r_held;
        n_lo        = r_lo;
        n_hix       = r_hix;
        n_mid       = r_mid;
        n_sec       = r_sec;
        n_off       = r_off;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (cfg_wr && (paddr[2] == REG_TOTAL)) begin
            n_total = pwdata;
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res   = '0;
                    n_sec   = i_in_item.sector_number;
                    n_state = S_EMIT;
                    case (i_in_item.opcode)
                        OP_CLEAR: begin
                            n_held = '0;
                        end
                        OP_APPEND: begin
                            if (i_in_item.entry_sectors != 32'd0) begin
                                if (r_held >= CNT_W'(MAX_EXTENTS)) begin
                                    n_res.status = ST_FULL;
                                end else begin
                                    n_held = r_held + CNT_W'(1);
                                end
                            end
                        end
                        OP_LOOKUP: begin
                            if (i_in_item.sector_number >= r_total) begin
                                n_res.status = ST_RANGE;
                            end else begin
                                n_lo    = '0;
                                n_hix   = r_held;
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            n_res = '0;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (r_lo < r_hix) begin
                    n_mid   = mid_idx;
                    n_state = S_CMP;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_CMP: begin
                if (r_sec < rd_entry.start) begin
                    n_hix   = {1'b0, r_mid};
                    n_state = S_READ;
                end else if ({1'b0, r_sec} >= end_sec) begin
                    n_lo    = {1'b0, r_mid} + CNT_W'(1);
                    n_state = S_READ;
                end else begin
                    n_state = S_OFF;
                end
            end
            S_OFF: begin
                n_off   = OFF_W'(rel_sec) << SECTOR_SHIFT;
                n_state = S_LEN;
            end
            S_LEN: begin
                n_res.status      = ST_OK;
                n_res.found       = 1'b1;
                n_res.hit_kind    = rd_entry.kind;
                n_res.hit_tag     = rd_entry.tag;
                n_res.byte_offset = off_sat ? 32'hffff_ffff : r_off[31:0];
                n_res.data_bytes  = '0;
                n_res.fill_byte   = 8'd0;
                case (rd_entry.kind)
                    KIND_VOLUME: begin
                        n_res.byte_offset = 32'd0;
                        n_res.data_bytes  = clamp_data(32'(SECTOR_BYTES));
                    end
                    KIND_DIR: begin
                        n_res.data_bytes = clamp_data(n_sec_bytes);
                        n_res.fill_byte  = DIR_FILL;
                    end
                    KIND_FILE: begin
                        n_res.data_bytes = clamp_data(n_sec_bytes);
                    end
                    default: begin
                        n_res.data_bytes = '0;
                    end
                endcase
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hix <= n_hix;
        r_mid <= n_mid;
        r_sec <= n_sec;
        r_off <= n_off;
        r_res <= n_res;
        r_out <= n_out;
    end

    `SEM_ASSERT_NOW(a_held_bound, 1'b1, r_held <= CNT_W'(MAX_EXTENTS), "entry count past table size")
    `SEM_ASSERT_NOW(a_probe_held, r_state == S_CMP, ({1'b0, r_mid} < r_held), "probe beyond held entries")
    `SEM_ASSERT_NOW(a_window, (r_state == S_READ) || (r_state == S_CMP), (r_lo <= r_hix) && (r_hix <= r_held), "search window inverted")
    `SEM_ASSERT_NEXT(a_lookup_start, in_acc && (i_in_item.opcode == OP_LOOKUP), (r_state == S_READ) || (r_state == S_EMIT), "lookup did not start")
    `SEM_ASSERT_NOW(a_hit_ok, r_out_valid && r_out.found, r_out.status == ST_OK, "hit with error status")

endmodule
